[rtl/fcsm_pkg.sv]
// fcsm_pkg: shared widths, command bytes, codes and types of the flash command core
// no dependencies
package fcsm_pkg;

   localparam int unsigned OFF_W        = 17;
   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned STATUS_W     = 4;
   localparam int unsigned CSR_IDX_W    = 2;
   localparam int unsigned CSR_W        = 17;
   localparam int unsigned REQ_TDATA_W  = 32;
   localparam int unsigned RSP_TDATA_W  = 16;

   localparam logic [BYTE_W-1:0] CMD_RESET   = 8'hF0;
   localparam logic [BYTE_W-1:0] CMD_UNLOCK1 = 8'hAA;
   localparam logic [BYTE_W-1:0] CMD_UNLOCK2 = 8'h55;
   localparam logic [BYTE_W-1:0] CMD_PROGRAM = 8'hA0;
   localparam logic [BYTE_W-1:0] CMD_ERASE   = 8'h80;
   localparam logic [BYTE_W-1:0] CMD_CONFIRM = 8'h30;
   localparam logic [BYTE_W-1:0] ERASED_BYTE = 8'hFF;

   localparam logic [OFF_W-1:0] UNLOCK_A_RESET = 17'd21845;
   localparam logic [OFF_W-1:0] UNLOCK_B_RESET = 17'd10922;

   localparam logic [CSR_IDX_W-1:0] CSR_UNLOCK_A = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UNLOCK_B = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PROTECT  = 2'd2;

   typedef enum logic [2:0] {
      PH_READ          = 3'd0,
      PH_UNLOCK2       = 3'd1,
      PH_COMMAND       = 3'd2,
      PH_PROGRAM       = 3'd3,
      PH_ERASE_UNLOCK1 = 3'd4,
      PH_ERASE_UNLOCK2 = 3'd5,
      PH_ERASE_CONFIRM = 3'd6
   } phase_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK                 = 4'd0,
      ST_NO_UNLOCK          = 4'd1,
      ST_BAD_UNLOCK2        = 4'd2,
      ST_WRONG_CMD_ADDR     = 4'd3,
      ST_BAD_CMD            = 4'd4,
      ST_PROTECTED          = 4'd5,
      ST_BAD_ERASE_UNLOCK1  = 4'd6,
      ST_BAD_ERASE_UNLOCK2  = 4'd7,
      ST_BAD_ERASE_CMD      = 4'd8
   } status_type;

   typedef enum logic [1:0] {
      SW_IDLE = 2'd0,
      SW_FIND = 2'd1,
      SW_FILL = 2'd2
   } sweep_state_type;

   typedef struct packed {
      logic       in_range;
      logic       prog_we;
      logic       erase_start;
      status_type status;
   } cmd_dec_type;

   typedef struct packed {
      logic busy;
      logic fill;
   } sweep_status_type;

endpackage

[rtl/fcsm_ram.sv]
// fcsm_ram: generic single write port, single read port RAM with registered read
// no dependencies
module fcsm_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/fcsm_cmd.sv]
// fcsm_cmd: command phase register and decode of one write beat
// depends on fcsm_pkg
module fcsm_cmd #(
   parameter int unsigned FLASH_BYTES = 131072
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic                        action,
   input  logic [fcsm_pkg::OFF_W-1:0]  offset,
   input  logic [fcsm_pkg::BYTE_W-1:0] write_data,
   input  logic [fcsm_pkg::OFF_W-1:0]  unlock_a,
   input  logic [fcsm_pkg::OFF_W-1:0]  unlock_b,
   input  logic                        write_protect,
   output fcsm_pkg::cmd_dec_type       dec
);
   import fcsm_pkg::*;

   localparam int unsigned ADDR_W  = $clog2(FLASH_BYTES);
   localparam int unsigned RANGE_W = (ADDR_W + 1 > OFF_W) ? ADDR_W + 1 : OFF_W;

   phase_type phase_ff;
   phase_type phase_in;

   always_comb begin
      phase_in        = phase_ff;
      dec.in_range    = (RANGE_W'(offset) < RANGE_W'(FLASH_BYTES));
      dec.prog_we     = 1'b0;
      dec.erase_start = 1'b0;
      dec.status      = ST_OK;
      if (action && dec.in_range) begin
         if (write_data == CMD_RESET && phase_ff != PH_PROGRAM) begin
            phase_in = PH_READ;
         end else begin
            unique case (phase_ff)
               PH_UNLOCK2: begin
                  if (offset == unlock_b && write_data == CMD_UNLOCK2) begin
                     phase_in = PH_COMMAND;
                  end else begin
                     phase_in   = PH_READ;
                     dec.status = ST_BAD_UNLOCK2;
                  end
               end
               PH_COMMAND: begin
                  if (offset != unlock_a) begin
                     phase_in   = PH_READ;
                     dec.status = ST_WRONG_CMD_ADDR;
                  end else if (write_data == CMD_PROGRAM) begin
                     phase_in = PH_PROGRAM;
                  end else if (write_data == CMD_ERASE) begin
                     phase_in = PH_ERASE_UNLOCK1;
                  end else begin
                     phase_in   = PH_READ;
                     dec.status = ST_BAD_CMD;
                  end
               end
               PH_PROGRAM: begin
                  phase_in = PH_READ;
                  if (write_protect) begin
                     dec.status = ST_PROTECTED;
                  end else begin
                     dec.prog_we = 1'b1;
                  end
               end
               PH_ERASE_UNLOCK1: begin
                  if (offset == unlock_a && write_data == CMD_UNLOCK1) begin
                     phase_in = PH_ERASE_UNLOCK2;
                  end else begin
                     phase_in   = PH_READ;
                     dec.status = ST_BAD_ERASE_UNLOCK1;
                  end
               end
               PH_ERASE_UNLOCK2: begin
                  if (offset == unlock_b && write_data == CMD_UNLOCK2) begin
                     phase_in = PH_ERASE_CONFIRM;
                  end else begin
                     phase_in   = PH_READ;
                     dec.status = ST_BAD_ERASE_UNLOCK2;
                  end
               end
               PH_ERASE_CONFIRM: begin
                  phase_in = PH_READ;
                  if (write_protect) begin
                     dec.status = ST_PROTECTED;
                  end else if (write_data != CMD_CONFIRM) begin
                     dec.status = ST_BAD_ERASE_CMD;
                  end else begin
                     dec.erase_start = 1'b1;
                  end
               end
               default: begin
                  if (offset == unlock_a && write_data == CMD_UNLOCK1) begin
                     phase_in = PH_UNLOCK2;
                  end else begin
                     phase_in   = PH_READ;
                     dec.status = ST_NO_UNLOCK;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_READ;
      end else if (step) begin
         phase_ff <= phase_in;
      end
   end

endmodule

[rtl/fcsm_sweep.sv]
// fcsm_sweep: fill sequencer, clears the whole array after reset and one sector on erase
// depends on fcsm_pkg
module fcsm_sweep #(
   parameter int unsigned FLASH_BYTES  = 131072,
   parameter int unsigned SECTOR_BYTES = 16384
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [fcsm_pkg::OFF_W-1:0]         target,
   output fcsm_pkg::sweep_status_type         status,
   output logic [$clog2(FLASH_BYTES)-1:0]     addr
);
   import fcsm_pkg::*;

   localparam int unsigned ADDR_W  = $clog2(FLASH_BYTES);
   localparam int unsigned RANGE_W = (ADDR_W + 1 > OFF_W) ? ADDR_W + 1 : OFF_W;
   localparam int unsigned SUM_W   = RANGE_W + 1;

   sweep_state_type  state_ff, state_in;
   logic [SUM_W-1:0] base_ff, base_in;
   logic [SUM_W-1:0] end_ff, end_in;
   logic [SUM_W-1:0] target_ff, target_in;
   logic [SUM_W-1:0] next_sector;
   logic [SUM_W-1:0] next_addr;

   always_comb begin
      state_in    = state_ff;
      base_in     = base_ff;
      end_in      = end_ff;
      target_in   = target_ff;
      next_sector = base_ff + SUM_W'(SECTOR_BYTES);
      next_addr   = base_ff + SUM_W'(1);
      unique case (state_ff)
         SW_IDLE: begin
            if (start) begin
               state_in  = SW_FIND;
               base_in   = '0;
               target_in = SUM_W'(target);
            end
         end
         SW_FIND: begin
            // step the sector base up until it covers the confirm offset
            if (next_sector <= target_ff) begin
               base_in = next_sector;
            end else begin
               state_in = SW_FILL;
               end_in   = (next_sector > SUM_W'(FLASH_BYTES)) ?
                          SUM_W'(FLASH_BYTES) : next_sector;
            end
         end
         SW_FILL: begin
            base_in = next_addr;
            if (next_addr == end_ff) begin
               state_in = SW_IDLE;
            end
         end
         default: begin
            state_in = SW_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= SW_FILL;
         base_ff   <= '0;
         end_ff    <= SUM_W'(FLASH_BYTES);
         target_ff <= '0;
      end else begin
         state_ff  <= state_in;
         base_ff   <= base_in;
         end_ff    <= end_in;
         target_ff <= target_in;
      end
   end

   assign status.busy = (state_ff != SW_IDLE);
   assign status.fill = (state_ff == SW_FILL);
   assign addr        = base_ff[ADDR_W-1:0];

endmodule

[rtl/flash_command_state_machine_core.sv]
// flash_command_state_machine_core: byte-wide NOR flash with AA/55 unlock command set
// depends on fcsm_pkg, fcsm_ram, fcsm_cmd, fcsm_sweep
//
// One request beat per clock for reads, programs and command writes while the response
// side does not stall; each response is registered after its beat has passed the request
// stage, which waits on the registered read of the array RAM, and a program writes back
// as its response is registered, with forwarding to the next beat. A sector erase stops
// request beats while the confirm beat completes, then while it locates the sector and
// fills it with FF (fewer bytes at the array end), one byte per cycle through the single
// RAM write port. After reset the same fill path clears the whole array before the first
// request beat is taken; csr writes are taken at any time.
module flash_command_state_machine_core #(
   parameter int unsigned FLASH_BYTES  = 131072,
   parameter int unsigned SECTOR_BYTES = 16384
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // offset [16:0], write_data [24:17], zero [31:25]
   input  logic [fcsm_pkg::REQ_TDATA_W-1:0] req_tdata,
   // action [0]
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // read_data [7:0], status [11:8], zero [15:12]
   output logic [fcsm_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                             csr_we,
   input  logic [fcsm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fcsm_pkg::CSR_W-1:0]       csr_wdata
);
   import fcsm_pkg::*;

   localparam int unsigned ADDR_W = $clog2(FLASH_BYTES);

   logic [OFF_W-1:0]  unlock_a_ff;
   logic [OFF_W-1:0]  unlock_b_ff;
   logic              protect_ff;

   logic              s1_valid_ff;
   logic              s1_action_ff;
   logic [OFF_W-1:0]  s1_offset_ff;
   logic [BYTE_W-1:0] s1_data_ff;

   logic              fwd_valid_ff;
   logic [ADDR_W-1:0] fwd_addr_ff;
   logic [BYTE_W-1:0] fwd_data_ff;

   logic              rsp_valid_ff;
   logic [BYTE_W-1:0] rsp_read_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   logic              req_accept;
   logic              s1_go;
   logic [ADDR_W-1:0] s1_addr;
   logic [BYTE_W-1:0] ram_rdata;
   logic [BYTE_W-1:0] stored;
   logic              prog_we;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [BYTE_W-1:0] ram_wdata;
   logic [ADDR_W-1:0] sweep_addr;
   cmd_dec_type       dec;
   sweep_status_type  sweep_st;

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         unlock_a_ff <= UNLOCK_A_RESET;
         unlock_b_ff <= UNLOCK_B_RESET;
         protect_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_UNLOCK_A: unlock_a_ff <= csr_wdata[OFF_W-1:0];
            CSR_UNLOCK_B: unlock_b_ff <= csr_wdata[OFF_W-1:0];
            CSR_PROTECT:  protect_ff  <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign req_accept = req_tvalid && req_tready;
   assign s1_go      = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !sweep_st.busy && (!s1_valid_ff || (s1_go && !dec.erase_start));

   assign s1_addr = ADDR_W'(s1_offset_ff);
   assign stored  = (fwd_valid_ff && fwd_addr_ff == s1_addr) ? fwd_data_ff : ram_rdata;
   assign prog_we = s1_go && dec.prog_we;

   assign ram_we    = sweep_st.fill || prog_we;
   assign ram_waddr = sweep_st.fill ? sweep_addr : s1_addr;
   assign ram_wdata = sweep_st.fill ? ERASED_BYTE : (stored & s1_data_ff);

   fcsm_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (FLASH_BYTES)
   ) u_array (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (req_accept),
      .raddr (ADDR_W'(req_tdata[OFF_W-1:0])),
      .rdata (ram_rdata)
   );

   fcsm_cmd #(
      .FLASH_BYTES (FLASH_BYTES)
   ) u_cmd (
      .clock         (clock),
      .reset         (reset),
      .step          (s1_go),
      .action        (s1_action_ff),
      .offset        (s1_offset_ff),
      .write_data    (s1_data_ff),
      .unlock_a      (unlock_a_ff),
      .unlock_b      (unlock_b_ff),
      .write_protect (protect_ff),
      .dec           (dec)
   );

   fcsm_sweep #(
      .FLASH_BYTES  (FLASH_BYTES),
      .SECTOR_BYTES (SECTOR_BYTES)
   ) u_sweep (
      .clock  (clock),
      .reset  (reset),
      .start  (s1_go && dec.erase_start),
      .target (s1_offset_ff),
      .status (sweep_st),
      .addr   (sweep_addr)
   );

   // request stage, holds the beat while its ram read completes and while the response is stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
      if (req_accept) begin
         s1_action_ff <= req_tuser;
         s1_offset_ff <= req_tdata[OFF_W-1:0];
         s1_data_ff   <= req_tdata[OFF_W+BYTE_W-1:OFF_W];
      end
   end

   // last write to the array, covers the read-during-write case
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (ram_we) begin
         fwd_valid_ff <= 1'b1;
      end
      if (ram_we) begin
         fwd_addr_ff <= ram_waddr;
         fwd_data_ff <= ram_wdata;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (s1_go) begin
         rsp_read_ff   <= (!s1_action_ff && dec.in_range) ? stored : '0;
         rsp_status_ff <= dec.status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - BYTE_W - STATUS_W)'(0), rsp_status_ff, rsp_read_ff};

   a_erase_starts_sweep: assert property (@(posedge clock) disable iff (reset)
      (s1_go && dec.erase_start) |=> sweep_st.busy)
      else $error("erase confirm did not start the sector fill");

   a_no_beat_during_sweep: assert property (@(posedge clock) disable iff (reset)
      sweep_st.busy |-> !req_accept)
      else $error("request beat taken while the array is being filled");

   a_program_unprotected: assert property (@(posedge clock) disable iff (reset)
      prog_we |-> (!protect_ff && !sweep_st.fill))
      else $error("program write while protected or during fill");

   a_stall_holds_stage: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_go) |=> (s1_valid_ff && $stable(s1_offset_ff)))
      else $error("request stage lost its beat while the response was stalled");

endmodule

[tb/tb_flash_command_state_machine_core.sv]
// tb_flash_command_state_machine_core: self-checking bench for the flash command core,
// a scripted opener then random command sequences under five csr settings with random idling
// depends on fcsm_pkg and flash_command_state_machine_core
module tb_flash_command_state_machine_core;
   import fcsm_pkg::*;

   localparam int unsigned FLASH_BYTES  = 131072;
   localparam int unsigned SECTOR_BYTES = 16384;
   localparam logic [OFF_W-1:0] TOP_OFF = OFF_W'(FLASH_BYTES - 1);
   localparam logic [OFF_W-1:0] UA      = UNLOCK_A_RESET;
   localparam logic [OFF_W-1:0] UB      = UNLOCK_B_RESET;
   localparam int NUM_SETTINGS = 5;
   localparam int SETTING_BEATS = 320;
   localparam int ERASES_PER_SETTING = 4;

   typedef struct packed {
      logic [BYTE_W-1:0] read_data;
      status_type        status;
   } flash_result_type;

   typedef struct packed {
      logic              is_write;
      logic [OFF_W-1:0]  off;
      logic [BYTE_W-1:0] data;
      logic              typed;
      flash_result_type  want;
   } script_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_W-1:0]       csr_wdata = '0;

   flash_command_state_machine_core #(
      .FLASH_BYTES  (FLASH_BYTES),
      .SECTOR_BYTES (SECTOR_BYTES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic [BYTE_W-1:0] model_flash [FLASH_BYTES];
   phase_type         model_phase;
   logic [OFF_W-1:0]  unlock_a;
   logic [OFF_W-1:0]  unlock_b;
   logic              protect_on;
   flash_result_type  pending_results [$];
   logic [OFF_W-1:0]  hot_offsets [$];
   script_row_type    script [25];
   int beats_sent, results_seen, mismatches;
   int programs_done, erases_done, error_statuses, erase_limit;
   bit req_calm, rsp_calm;

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("result %0d: %s is %0h, expected %0h", results_seen, what, got, want);
      mismatches++;
   endtask

   function automatic flash_result_type flash_apply_beat(input logic is_write,
                                                         input logic [OFF_W-1:0] off,
                                                         input logic [BYTE_W-1:0] data);
      flash_result_type res;
      phase_type        nxt;
      int unsigned      base;
      res = '{read_data: '0, status: ST_OK};
      if (off >= FLASH_BYTES) return res;
      if (!is_write) begin
         res.read_data = model_flash[off];
         return res;
      end
      nxt = PH_READ;
      if (data == CMD_RESET && model_phase != PH_PROGRAM) begin
         nxt = PH_READ;
      end else begin
         case (model_phase)
            PH_UNLOCK2: begin
               if (off == unlock_b && data == CMD_UNLOCK2) nxt = PH_COMMAND;
               else res.status = ST_BAD_UNLOCK2;
            end
            PH_COMMAND: begin
               if (off != unlock_a) res.status = ST_WRONG_CMD_ADDR;
               else if (data == CMD_PROGRAM) nxt = PH_PROGRAM;
               else if (data == CMD_ERASE) nxt = PH_ERASE_UNLOCK1;
               else res.status = ST_BAD_CMD;
            end
            PH_PROGRAM: begin
               if (protect_on) begin
                  res.status = ST_PROTECTED;
               end else begin
                  model_flash[off] = model_flash[off] & data;
                  programs_done++;
               end
            end
            PH_ERASE_UNLOCK1: begin
               if (off == unlock_a && data == CMD_UNLOCK1) nxt = PH_ERASE_UNLOCK2;
               else res.status = ST_BAD_ERASE_UNLOCK1;
            end
            PH_ERASE_UNLOCK2: begin
               if (off == unlock_b && data == CMD_UNLOCK2) nxt = PH_ERASE_CONFIRM;
               else res.status = ST_BAD_ERASE_UNLOCK2;
            end
            PH_ERASE_CONFIRM: begin
               if (protect_on) begin
                  res.status = ST_PROTECTED;
               end else if (data != CMD_CONFIRM) begin
                  res.status = ST_BAD_ERASE_CMD;
               end else begin
                  base = (off / SECTOR_BYTES) * SECTOR_BYTES;
                  for (int unsigned i = 0; i < SECTOR_BYTES && base + i < FLASH_BYTES; i++)
                     model_flash[base + i] = ERASED_BYTE;
                  erases_done++;
               end
            end
            default: begin
               if (off == unlock_a && data == CMD_UNLOCK1) nxt = PH_UNLOCK2;
               else res.status = ST_NO_UNLOCK;
            end
         endcase
      end
      model_phase = nxt;
      if (res.status != ST_OK) error_statuses++;
      return res;
   endfunction

   function automatic logic [OFF_W-1:0] pick_offset();
      if (hot_offsets.size() > 0 && $urandom_range(0, 1) == 0)
         return hot_offsets[$urandom_range(0, hot_offsets.size() - 1)];
      return OFF_W'($urandom_range(0, FLASH_BYTES - 1));
   endfunction

   // called at a falling edge, returns at the falling edge after the beat is taken
   task automatic send_beat(input logic is_write, input logic [OFF_W-1:0] off,
                            input logic [BYTE_W-1:0] data, input logic typed,
                            input flash_result_type want);
      int gap;
      flash_result_type res;
      gap = req_calm ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      // hold the sector erase count down so the run stays short
      if (is_write && !typed && model_phase == PH_ERASE_CONFIRM && !protect_on &&
          erases_done >= erase_limit && data == CMD_CONFIRM)
         data = CMD_CONFIRM + 8'd1;
      req_tvalid <= 1'b1;
      req_tuser  <= is_write;
      req_tdata  <= {{(REQ_TDATA_W - OFF_W - BYTE_W){1'b0}}, data, off};
      do @(posedge clock); while (req_tready !== 1'b1);
      res = flash_apply_beat(is_write, off, data);
      pending_results.insert(pending_results.size(), typed ? want : res);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic write_settings(input logic [OFF_W-1:0] a, input logic [OFF_W-1:0] b,
                                 input logic wp);
      logic [CSR_W-2:0] junk;
      junk = (CSR_W-1)'($urandom);
      csr_we    <= 1'b1;
      csr_index <= CSR_UNLOCK_A;
      csr_wdata <= a;
      @(negedge clock);
      csr_index <= CSR_UNLOCK_B;
      csr_wdata <= b;
      @(negedge clock);
      csr_index <= CSR_PROTECT;
      csr_wdata <= {junk, wp};
      @(negedge clock);
      csr_we <= 1'b0;
      unlock_a   = a;
      unlock_b   = b;
      protect_on = wp;
   endtask

   task automatic random_burst();
      logic [OFF_W-1:0]  so [6];
      logic [BYTE_W-1:0] sd [6];
      logic [BYTE_W-1:0] rb;
      int n, pick, bad;
      if ($urandom_range(0, 19) == 0) req_calm = !req_calm;
      if ($urandom_range(0, 99) == 0) drain_results();
      rb = BYTE_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         send_beat(1'b1, OFF_W'($urandom_range(0, FLASH_BYTES - 1)), rb, 1'b0, '0);
      end else if (pick < 35) begin
         send_beat(1'b0, pick_offset(), rb, 1'b0, '0);
      end else begin
         so[0] = unlock_a; sd[0] = CMD_UNLOCK1;
         so[1] = unlock_b; sd[1] = CMD_UNLOCK2;
         so[2] = unlock_a;
         if (pick < 75) begin
            sd[2] = CMD_PROGRAM;
            so[3] = pick_offset();
            sd[3] = ($urandom_range(0, 9) == 0) ? CMD_RESET : rb;
            n = 4;
         end else begin
            sd[2] = CMD_ERASE;
            so[3] = unlock_a; sd[3] = CMD_UNLOCK1;
            so[4] = unlock_b; sd[4] = CMD_UNLOCK2;
            so[5] = OFF_W'($urandom_range(0, FLASH_BYTES - 1));
            sd[5] = CMD_CONFIRM;
            n = 6;
         end
         // broken sequences: one step gets a wrong offset, a wrong byte or a reset command
         if ($urandom_range(0, 4) == 0) begin
            bad = $urandom_range(0, n - 1);
            case ($urandom_range(0, 2))
               0: so[bad] = OFF_W'($urandom_range(0, FLASH_BYTES - 1));
               1: sd[bad] = rb;
               default: sd[bad] = CMD_RESET;
            endcase
         end
         for (int i = 0; i < n; i++) send_beat(1'b1, so[i], sd[i], 1'b0, '0);
         hot_offsets.insert(hot_offsets.size(), so[n - 1]);
         if (hot_offsets.size() > 32) void'(hot_offsets.pop_front());
      end
   endtask

   initial begin : rsp_side
      int stall;
      flash_result_type got;
      flash_result_type want;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 63) == 0) rsp_calm = !rsp_calm;
         stall = rsp_calm ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         got.read_data = rsp_tdata[BYTE_W-1:0];
         got.status    = status_type'(rsp_tdata[BYTE_W+STATUS_W-1:BYTE_W]);
         results_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected beat", 32'(rsp_tdata), 0);
         end else begin
            want = pending_results.pop_front();
            if (got.read_data !== want.read_data)
               report_mismatch("read_data", 32'(got.read_data), 32'(want.read_data));
            if (got.status !== want.status)
               report_mismatch("status", 32'(got.status), 32'(want.status));
         end
         @(negedge clock);
      end
   end

   initial begin : req_side
      logic [OFF_W-1:0] a, b;
      logic wp;
      script = '{
         '{1'b0, 17'd0,   8'h00,       1'b1, '{ERASED_BYTE, ST_OK}},
         '{1'b0, TOP_OFF, 8'h00,       1'b1, '{ERASED_BYTE, ST_OK}},
         '{1'b1, TOP_OFF, 8'hFF,       1'b1, '{8'h00, ST_NO_UNLOCK}},
         '{1'b1, UA,      CMD_UNLOCK1, 1'b0, '0},
         '{1'b1, UB,      CMD_UNLOCK2, 1'b0, '0},
         '{1'b1, UA,      CMD_PROGRAM, 1'b0, '0},
         '{1'b1, TOP_OFF, CMD_RESET,   1'b0, '0},
         '{1'b0, TOP_OFF, 8'h00,       1'b1, '{CMD_RESET, ST_OK}},
         '{1'b1, UA,      CMD_UNLOCK1, 1'b0, '0},
         '{1'b1, UB,      8'h00,       1'b1, '{8'h00, ST_BAD_UNLOCK2}},
         '{1'b1, UA,      CMD_UNLOCK1, 1'b0, '0},
         '{1'b1, UB,      CMD_UNLOCK2, 1'b0, '0},
         '{1'b1, 17'd0,   CMD_PROGRAM, 1'b1, '{8'h00, ST_WRONG_CMD_ADDR}},
         '{1'b1, UA,      CMD_UNLOCK1, 1'b0, '0},
         '{1'b1, UB,      CMD_UNLOCK2, 1'b0, '0},
         '{1'b1, UA,      8'h77,       1'b1, '{8'h00, ST_BAD_CMD}},
         '{1'b1, UA,      CMD_UNLOCK1, 1'b0, '0},
         '{1'b1, 17'd0,   CMD_RESET,   1'b1, '{8'h00, ST_OK}},
         '{1'b1, UA,      CMD_UNLOCK1, 1'b0, '0},
         '{1'b1, UB,      CMD_UNLOCK2, 1'b0, '0},
         '{1'b1, UA,      CMD_ERASE,   1'b0, '0},
         '{1'b1, UA,      CMD_UNLOCK1, 1'b0, '0},
         '{1'b1, UB,      CMD_UNLOCK2, 1'b0, '0},
         '{1'b1, TOP_OFF, CMD_CONFIRM, 1'b0, '0},
         '{1'b0, TOP_OFF, 8'h00,       1'b1, '{ERASED_BYTE, ST_OK}}
      };
      for (int unsigned i = 0; i < FLASH_BYTES; i++) model_flash[i] = ERASED_BYTE;
      model_phase = PH_READ;
      unlock_a    = UNLOCK_A_RESET;
      unlock_b    = UNLOCK_B_RESET;
      protect_on  = 1'b0;
      erase_limit = 1;
      req_calm    = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (script[i])
         send_beat(script[i].is_write, script[i].off, script[i].data, script[i].typed,
                   script[i].want);
      for (int s = 0; s < NUM_SETTINGS; s++) begin
         drain_results();
         case (s)
            0: begin a = '0; b = TOP_OFF; wp = 1'b0; end
            1: begin a = TOP_OFF; b = '0; wp = 1'b1; end
            2: begin
               a = OFF_W'($urandom_range(0, FLASH_BYTES - 1));
               b = OFF_W'($urandom_range(0, FLASH_BYTES - 1));
               wp = 1'b0;
            end
            3: begin a = OFF_W'($urandom_range(0, FLASH_BYTES - 1)); b = a; wp = 1'b0; end
            default: begin a = UNLOCK_A_RESET; b = UNLOCK_B_RESET; wp = 1'b1; end
         endcase
         write_settings(a, b, wp);
         erase_limit = erases_done + ERASES_PER_SETTING;
         for (int target = beats_sent + SETTING_BEATS; beats_sent < target; )
            random_burst();
      end
      drain_results();
      repeat (20) @(posedge clock);
      $display("%0d beats over %0d csr settings plus the reset one", beats_sent, NUM_SETTINGS);
      $display("%0d programs, %0d sector erases, %0d error statuses",
               programs_done, erases_done, error_statuses);
      if (mismatches == 0) begin
         $display("flash_command_state_machine_core: match");
      end else begin
         $display("flash_command_state_machine_core: mismatch");
      end
      $finish;
   end

   initial begin : watchdog
      #20_000_000;
      $display("flash_command_state_machine_core: mismatch");
      $finish;
   end

endmodule
